// ===== hw/rtl/pca_pkg.sv =====
// Shared types, request codes and default sizes for the palette color allocator.
// No dependencies; pca_vbits and the allocator core import this package.

package pca_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int ALLOC_LIMIT_DEF   = 255;

	localparam logic [2:0] REQ_ADD   = 3'd0;
	localparam logic [2:0] REQ_SET   = 3'd1;
	localparam logic [2:0] REQ_CLEAR = 3'd2;
	localparam logic [2:0] REQ_READ  = 3'd3;
	localparam logic [2:0] REQ_FLUSH = 3'd4;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] color_argb;
		logic [7:0]  entry_index;
	} pca_req_t;

	typedef struct packed {
		logic [7:0]  result_index;
		logic        was_found;
		logic        table_full;
		logic [31:0] entry_argb;
		logic        changed_flag;
	} pca_rsp_t;

	// Control for the per-entry valid bits.
	typedef struct packed {
		logic set;
		logic clr_all;
		logic rd;
	} pca_vb_ctl_t;

endpackage

// ===== hw/rtl/pca_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Payload types come from pca_pkg at the point of instantiation.

interface pca_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/pca_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; sized by WIDTH and DEPTH.

module pca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/pca_vbits.sv =====
// Per-entry written flags for the color table, cleared at once by reset or clear.
// Depends on pca_pkg for the control struct.

module pca_vbits import pca_pkg::*; #(
	parameter int ENTRIES = TABLE_ENTRIES_DEF,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pca_vb_ctl_t   ctl,
	input  logic [AW-1:0] set_addr,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_vld_s1
);
	logic [ENTRIES-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				vld_q <= '0;
			end else if (ctl.set) begin
				vld_q[set_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end
endmodule

// ===== hw/rtl/palette_color_allocator_core.sv =====
// Palette color allocator: ARGB lookup table with duplicate-free allocation.
// Depends on pca_pkg, pca_stream_if, pca_ram and pca_vbits.
//
// Usage:
//   req carries one request transaction (req_type, color_argb, entry_index);
//   rsp returns exactly one response transaction per request, in order.
//   The block works on one request at a time: req.ready is high only while
//   the engine is idle, and it is idle again once the response is loaded
//   into the output register, so the next request can enter while the last
//   response still waits on rsp.
// Sequence (accept to response valid, receiver ready):
//   set, clear, flush, unused codes go straight to the execute state; read
//   makes one RAM read on accept; add first searches the in-use entries and
//   reads one stored entry per cycle through the single RAM read port.
// Reset: the table reads as all zero (per-entry written flags are cleared),
//   used_count is 1 and the changed flag is 1; no clearing pass is needed.
//   A clear request empties the table the same way (used_count 1) but clears the changed flag.
// Stall: when rsp.ready is low the response holds in its register; a
//   finished request then waits in the execute state, and no table update
//   is made until its response can be loaded.

module palette_color_allocator_core import pca_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int ALLOC_LIMIT   = ALLOC_LIMIT_DEF
) (
	input logic           clk,
	input logic           arst_n,
	pca_stream_if.sink    req,
	pca_stream_if.source  rsp
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	// Appending is allowed only below the smaller of the two limits.
	localparam logic [7:0] APPEND_LIMIT =
		8'((ALLOC_LIMIT < TABLE_ENTRIES) ? ALLOC_LIMIT : TABLE_ENTRIES);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_EXEC   = 2'd2;

	logic [1:0]  state_q;
	pca_req_t    rq_q;
	logic        in_range_q;
	logic        hit_q;
	logic [7:0]  hit_idx_q;
	logic [7:0]  rd_addr_q;
	logic        cmp_vld_s1;
	logic [7:0]  cmp_idx_s1;
	logic [7:0]  used_q;
	logic        changed_q;
	logic        out_vld_q;
	pca_rsp_t    out_q;

	logic          accept;
	logic          in_range_in;
	logic          search_issue;
	logic          hit_now;
	logic          exec_fire;
	logic          room;
	logic [31:0]   ram_rdata;
	logic [31:0]   entry_data;
	logic          ent_vld_s1;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	pca_vb_ctl_t   vb_ctl;
	pca_rsp_t      rsp_d;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range_in = {1'b0, req.payload.entry_index} < 9'(TABLE_ENTRIES);

	// Unwritten entries read as zero.
	assign entry_data = ent_vld_s1 ? ram_rdata : 32'd0;

	// Search pipeline: issue one address per cycle, compare the returned word next cycle.
	assign hit_now      = (state_q == ST_SEARCH) && cmp_vld_s1 && (entry_data == rq_q.color_argb);
	assign search_issue = (state_q == ST_SEARCH) && !hit_now && (rd_addr_q < used_q);

	assign exec_fire = (state_q == ST_EXEC) && (!out_vld_q || rsp.ready);
	assign room      = used_q < APPEND_LIMIT;

	// Memory port control.
	always_comb begin
		ram_re    = search_issue || (accept && req.payload.req_type == REQ_READ);
		ram_raddr = search_issue ? rd_addr_q[AW-1:0] : req.payload.entry_index[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = rq_q.entry_index[AW-1:0];
		vb_ctl    = '0;
		vb_ctl.rd = ram_re;
		if (exec_fire) begin
			case (rq_q.req_type)
				REQ_ADD: begin
					if (!hit_q && room) begin
						ram_we    = 1'b1;
						ram_waddr = used_q[AW-1:0];
					end
				end
				REQ_SET: begin
					ram_we = in_range_q;
				end
				REQ_CLEAR: begin
					vb_ctl.clr_all = 1'b1;
				end
				default: begin
				end
			endcase
		end
		vb_ctl.set = ram_we;
	end

	// Response for the request in the execute state.
	always_comb begin
		rsp_d              = '0;
		rsp_d.changed_flag = changed_q;
		case (rq_q.req_type)
			REQ_ADD: begin
				if (hit_q) begin
					rsp_d.result_index = hit_idx_q;
					rsp_d.was_found    = 1'b1;
				end else if (room) begin
					rsp_d.result_index = used_q;
				end else begin
					rsp_d.table_full = 1'b1;
				end
			end
			REQ_READ: begin
				rsp_d.entry_argb = in_range_q ? entry_data : 32'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= 8'd1;
			changed_q  <= 1'b1;
			out_vld_q  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			// Load a new response, else drop the one the receiver took.
			if (exec_fire) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_addr_q  <= 8'd1;
						cmp_vld_s1 <= 1'b0;
						hit_q      <= 1'b0;
						state_q    <= (req.payload.req_type == REQ_ADD) ? ST_SEARCH : ST_EXEC;
					end
				end
				ST_SEARCH: begin
					cmp_vld_s1 <= search_issue;
					cmp_idx_s1 <= rd_addr_q;
					if (search_issue) begin
						rd_addr_q <= 8'(rd_addr_q + 8'd1);
					end
					if (hit_now) begin
						hit_q     <= 1'b1;
						hit_idx_q <= cmp_idx_s1;
						state_q   <= ST_EXEC;
					end else if (!search_issue) begin
						// Nothing left to issue and no match this cycle: miss.
						hit_q   <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q   <= ST_IDLE;
						case (rq_q.req_type)
							REQ_ADD: begin
								if (!hit_q && room) begin
									used_q    <= 8'(used_q + 8'd1);
									changed_q <= 1'b1;
								end
							end
							REQ_SET: begin
								if (in_range_q) begin
									changed_q <= 1'b1;
								end
							end
							REQ_CLEAR: begin
								used_q    <= 8'd1;
								changed_q <= 1'b0;
							end
							REQ_FLUSH: begin
								changed_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request and response payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rq_q       <= req.payload;
			in_range_q <= in_range_in;
		end
		if (exec_fire) begin
			out_q <= rsp_d;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	pca_ram #(
		.WIDTH (32),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rq_q.color_argb),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pca_vbits #(
		.ENTRIES (TABLE_ENTRIES)
	) u_vbits (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (vb_ctl),
		.set_addr  (ram_waddr),
		.rd_addr   (ram_raddr),
		.rd_vld_s1 (ent_vld_s1)
	);

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != 8'd0) && (used_q <= APPEND_LIMIT))
		else $error("used count out of range");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (rd_addr_q <= used_q))
		else $error("search address passed the used count");

	a_hit_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EXEC) && hit_q) |-> ((hit_idx_q != 8'd0) && (hit_idx_q < used_q)))
		else $error("match index outside the in-use entries");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && (rq_q.req_type == REQ_CLEAR)) |=> ((used_q == 8'd1) && !changed_q))
		else $error("clear left count or changed flag set");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_EXEC))
		else $error("response raised outside the execute state");
endmodule
